// File: hdl/unique_value_list_top_defines.svh
// Assertion helpers shared by the list block.
`ifndef UNIQUE_VALUE_LIST_TOP_DEFINES_SVH
`define UNIQUE_VALUE_LIST_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UVL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define UVL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/uvl_pkg.sv
package uvl_pkg;

  localparam int CAPACITY    = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int COUNT_OUT_W = 11;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [IDX_W-1:0]       idx_t;

  // one write and one read port per cycle
  typedef struct packed {
    logic   we;
    idx_t   waddr;
    value_t wdata;
    logic   re;
    idx_t   raddr;
  } mem_req_t;

  // sign extend the 32-bit field, keep the low VALUE_WIDTH bits
  function automatic value_t to_value(logic signed [31:0] raw);
    logic signed [63:0] ext;
    ext = 64'(raw);
    return ext[VALUE_WIDTH-1:0];
  endfunction

endpackage

// File: hdl/uvl_store.sv
module uvl_store (
  input  logic                clk_i,
  input  uvl_pkg::mem_req_t   req_i,
  output uvl_pkg::value_t     rdata_o
);

  uvl_pkg::value_t mem [uvl_pkg::CAPACITY];
  uvl_pkg::value_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // registered read, data valid in the cycle after the request
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/unique_value_list_top.sv
// Ordered list of distinct signed integers, fixed capacity.
// Command channel: mode_i and value_i are taken at the clock edge where start
// is high and busy is low. busy then stays high until the operation is done.
// Result channel: was_present_o, count_o and status_o are valid for exactly one
// cycle while result_valid_o is high; there is no back-pressure, the receiver
// must take the transfer in that cycle.
// Search: a linear search walks the entries through the single read port of
// the entry store, one entry per cycle, pipelined behind its registered read.
// A miss of any kind ends once every entry below the count is read; a query or
// append hit ends as soon as the hit is seen. For a delete hit, wherever the
// hit lies, the search stops at the hit and the tail move covers the rest,
// one entry per cycle. Clear reads no entries.
// One command is in flight at a time.
// A new command may be issued in the cycle the strobe is shown.
// Reset empties the list (count 0) at once; the entry store itself is not
// cleared, only entries below the count are ever read.
// Append of a new value to a full list is dropped with status 1.
module unique_value_list_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [31:0] value_i,
  output logic        result_valid_o,
  output logic        was_present_o,
  output logic [10:0] count_o,
  output logic        status_o
);

  `include "unique_value_list_top_defines.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT
  } state_e;

  state_e                      state_q;
  uvl_pkg::mode_e              mode_q;
  uvl_pkg::value_t             val_q;
  logic [uvl_pkg::CNT_W-1:0]   count_q;
  logic [uvl_pkg::CNT_W-1:0]   idx_q;    // next entry to read
  uvl_pkg::idx_t               pidx_q;   // entry whose data arrives now
  logic                        pend_q;   // read data valid this cycle
  logic                        valid_q;
  logic                        was_q;
  logic                        status_q;

  uvl_pkg::mem_req_t           mem_req;
  uvl_pkg::value_t             rdata;
  logic                        match;
  logic                        at_end;
  logic                        has_room;

  uvl_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  assign match    = pend_q && (rdata == val_q);
  assign at_end   = (idx_q >= count_q);
  assign has_room = (count_q < uvl_pkg::CNT_W'(uvl_pkg::CAPACITY));

  // store port: search issues one read a cycle, and an append miss with room
  // writes at count; shift reads entry j while writing entry j-1 one place down
  always_comb begin
    mem_req = '0;
    case (state_q)
      ST_SEARCH: begin
        if (mode_q != uvl_pkg::MODE_CLEAR && !match) begin
          if (!at_end) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = idx_q[uvl_pkg::IDX_W-1:0];
          end else if (mode_q == uvl_pkg::MODE_APPEND && has_room) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = count_q[uvl_pkg::IDX_W-1:0];
            mem_req.wdata = val_q;
          end
        end
      end
      ST_SHIFT: begin
        if (pend_q) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pidx_q - 1'b1;
          mem_req.wdata = rdata;
        end
        if (!at_end) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_q[uvl_pkg::IDX_W-1:0];
        end
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mode_q   <= uvl_pkg::MODE_QUERY;
      val_q    <= '0;
      count_q  <= '0;
      idx_q    <= '0;
      pidx_q   <= '0;
      pend_q   <= 1'b0;
      valid_q  <= 1'b0;
      was_q    <= 1'b0;
      status_q <= uvl_pkg::STATUS_OK;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            mode_q  <= uvl_pkg::mode_e'(mode_i);
            val_q   <= uvl_pkg::to_value(value_i);
            idx_q   <= '0;
            pend_q  <= 1'b0;
            state_q <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (mode_q == uvl_pkg::MODE_CLEAR) begin
            count_q  <= '0;
            was_q    <= 1'b0;
            status_q <= uvl_pkg::STATUS_OK;
            valid_q  <= 1'b1;
            state_q  <= ST_IDLE;
          end else if (match) begin
            was_q    <= 1'b1;
            status_q <= uvl_pkg::STATUS_OK;
            if (mode_q == uvl_pkg::MODE_DELETE) begin
              // move the tail down over the hit
              idx_q   <= uvl_pkg::CNT_W'(pidx_q) + 1'b1;
              pend_q  <= 1'b0;
              state_q <= ST_SHIFT;
            end else begin
              valid_q <= 1'b1;
              state_q <= ST_IDLE;
            end
          end else if (at_end) begin
            // value absent
            was_q    <= 1'b0;
            status_q <= uvl_pkg::STATUS_OK;
            if (mode_q == uvl_pkg::MODE_APPEND) begin
              if (has_room) begin
                count_q <= count_q + 1'b1;
              end else begin
                status_q <= uvl_pkg::STATUS_FULL;
              end
            end
            valid_q <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            pend_q <= 1'b1;
            pidx_q <= idx_q[uvl_pkg::IDX_W-1:0];
            idx_q  <= idx_q + 1'b1;
          end
        end
        ST_SHIFT: begin
          if (!at_end) begin
            pend_q <= 1'b1;
            pidx_q <= idx_q[uvl_pkg::IDX_W-1:0];
            idx_q  <= idx_q + 1'b1;
          end else begin
            // last pending write goes out this cycle
            pend_q  <= 1'b0;
            count_q <= count_q - 1'b1;
            valid_q <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = valid_q;
  assign was_present_o  = was_q;
  assign count_o        = uvl_pkg::COUNT_OUT_W'(count_q);
  assign status_o       = status_q;

  `UVL_ASSERT_NOW(a_count_bound, 1'b1, count_q <= uvl_pkg::CNT_W'(uvl_pkg::CAPACITY), "count above capacity")
  `UVL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command did not raise busy")
  `UVL_ASSERT_NEXT(a_strobe_single, result_valid_o, !result_valid_o, "result strobe longer than one cycle")
  `UVL_ASSERT_NOW(a_full_flag, result_valid_o && status_o, !was_present_o && !has_room, "full status on a hit or with room left")

endmodule
